[rtl/core/message_slot_mailbox_macros.svh]
// ----------------------------------------------------------------------------
// message_slot_mailbox_macros
// assertion helpers used by the mailbox rtl
// ----------------------------------------------------------------------------
`ifndef MESSAGE_SLOT_MAILBOX_MACROS_SVH
`define MESSAGE_SLOT_MAILBOX_MACROS_SVH

// same-cycle implication, held off during reset
`define MSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/msm_pkg.sv]
// ----------------------------------------------------------------------------
// msm_pkg
// types and codes of the message slot mailbox
// ----------------------------------------------------------------------------
package msm_pkg;

    localparam int SLOT_COUNT_DEF    = 16;
    localparam int MESSAGE_BYTES_DEF = 64;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 16;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECV = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEND = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ERR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [LEN_W-1:0] PEND_MAX = 7'd127;

    // per-slot header
    typedef struct packed {
        logic [ID_W-1:0]  receiver;
        logic [ID_W-1:0]  sender;
        logic [LEN_W-1:0] length;
    } meta_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_SCAN,
        S_SEND_STORE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DLV_RD,
        S_DLV_CAP,
        S_EMIT
    } state_t;

endpackage

[rtl/core/msm_if.sv]
// ----------------------------------------------------------------------------
// msm_if
// request and response channels of the mailbox
// ----------------------------------------------------------------------------
interface msm_req_if import msm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   receiver_id;
    logic [ID_W-1:0]   sender_id;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_last;
    logic [LEN_W-1:0]  capacity;

    modport source (output valid, command, receiver_id, sender_id, data_byte,
                    byte_last, capacity, input ready);
    modport sink   (input valid, command, receiver_id, sender_id, data_byte,
                    byte_last, capacity, output ready);
endinterface

interface msm_rsp_if import msm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] byte_value;
    logic              result_last;
    logic [ID_W-1:0]   sender_id_out;
    logic [LEN_W-1:0]  count;

    modport source (output valid, status, byte_value, result_last, sender_id_out,
                    count, input ready);
    modport sink   (input valid, status, byte_value, result_last, sender_id_out,
                    count, output ready);
endinterface

[rtl/core/msm_ram.sv]
// ----------------------------------------------------------------------------
// msm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module msm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/message_slot_mailbox.sv]
// ----------------------------------------------------------------------------
// message_slot_mailbox
// slot table mailbox: byte-run sends, receives by receiver id, pending counts
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | command, receiver_id, sender_id, data_byte, byte_last, capacity
//  rsp     | out | status, byte_value, result_last, sender_id_out, count
//
//  one sequencer walks the slots one per step; req is ready only when idle
//  send byte: a store step, plus a free-slot scan of up to SLOT_COUNT slots on a
//  run's first byte. receive / pending: a header ram read then a compare per slot
//  scanned, then a byte ram read, capture and emit per delivered byte
//  rsp stalls hold the sequencer in its emit step; no clearing pass, use
//  flags reset at once with rst_n
// ----------------------------------------------------------------------------
module message_slot_mailbox import msm_pkg::*; #(
    parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
    parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    msm_req_if.sink    req,
    msm_rsp_if.source  rsp
);

`include "message_slot_mailbox_macros.svh"

    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BYTE_DEPTH = SLOT_COUNT * MESSAGE_BYTES;
    localparam int BA_W       = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;
    localparam int META_W     = $bits(meta_t);
    localparam logic [LEN_W-1:0]  MSG_MAX   = LEN_W'(MESSAGE_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    state_t state_reg, state_next;

    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic              send_active_reg, send_active_next;
    logic [SLOT_W-1:0] send_slot_reg, send_slot_next;
    logic [LEN_W-1:0]  send_count_reg, send_count_next;
    logic              send_failed_reg, send_failed_next;
    logic [ID_W-1:0]   send_rcv_reg, send_rcv_next;
    logic [ID_W-1:0]   send_snd_reg, send_snd_next;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ID_W-1:0]   rcv_reg, rcv_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [LEN_W-1:0]  cap_reg, cap_next;

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  pend_reg, pend_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [ID_W-1:0]   hit_snd_reg, hit_snd_next;
    logic [LEN_W-1:0]  dlv_n_reg, dlv_n_next;
    logic [LEN_W-1:0]  dlv_j_reg, dlv_j_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [BYTE_W-1:0] res_byte_reg, res_byte_next;
    logic              res_last_reg, res_last_next;
    logic [ID_W-1:0]   res_snd_reg, res_snd_next;
    logic [LEN_W-1:0]  res_count_reg, res_count_next;

    logic              ov_reg, ov_next;
    logic [STAT_W-1:0] o_status_reg, o_status_next;
    logic [BYTE_W-1:0] o_byte_reg, o_byte_next;
    logic              o_last_reg, o_last_next;
    logic [ID_W-1:0]   o_snd_reg, o_snd_next;
    logic [LEN_W-1:0]  o_count_reg, o_count_next;

    logic              req_xfer;
    logic              out_free;
    logic              store_ok;
    logic              fail_now;
    logic [LEN_W-1:0]  count_inc;
    logic              scan_hit;
    logic              scan_end;
    logic [LEN_W-1:0]  len_clip;
    logic [LEN_W-1:0]  dlv_len;
    logic              dlv_end;

    logic              meta_we;
    meta_t             meta_wdata;
    logic              meta_re;
    logic [META_W-1:0] meta_rbits;
    meta_t             meta_rd;

    logic              byte_we;
    logic [BA_W-1:0]   byte_waddr;
    logic              byte_re;
    logic [BA_W-1:0]   byte_raddr;
    logic [BYTE_W-1:0] byte_rdata;

    // slot headers and message bytes
    msm_ram #(.WIDTH(META_W), .DEPTH(SLOT_COUNT)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (send_slot_reg),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (idx_reg),
        .rdata (meta_rbits)
    );

    msm_ram #(.WIDTH(BYTE_W), .DEPTH(BYTE_DEPTH)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_reg),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    assign meta_rd = meta_t'(meta_rbits);

    // handshake terms
    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign out_free  = !ov_reg || rsp.ready;

    // send byte store terms
    assign store_ok  = !send_failed_reg && (send_count_reg < MSG_MAX);
    assign fail_now  = send_failed_reg || !store_ok;
    assign count_inc = send_count_reg + LEN_W'(1);

    // scan compare terms
    assign scan_hit = used_reg[idx_reg] && (meta_rd.receiver == rcv_reg);
    assign scan_end = (idx_reg == SLOT_LAST);
    assign len_clip = (meta_rd.length > MSG_MAX) ? MSG_MAX : meta_rd.length;
    assign dlv_len  = (cap_reg < len_clip) ? cap_reg : len_clip;
    assign dlv_end  = (dlv_j_reg + LEN_W'(1) == dlv_n_reg);

    // memory ports
    assign byte_we    = (state_reg == S_SEND_STORE) && store_ok;
    assign byte_waddr = BA_W'(send_slot_reg) * BA_W'(MESSAGE_BYTES) + BA_W'(send_count_reg);
    assign byte_re    = (state_reg == S_DLV_RD);
    assign byte_raddr = BA_W'(hit_slot_reg) * BA_W'(MESSAGE_BYTES) + BA_W'(dlv_j_reg);
    assign meta_re    = (state_reg == S_SCAN_RD);
    assign meta_we    = (state_reg == S_SEND_STORE) && last_reg && !fail_now;
    assign meta_wdata = '{receiver: send_rcv_reg, sender: send_snd_reg, length: count_inc};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.command)
                        CMD_SEND:
                        begin
                            if (!send_active_reg && (req.receiver_id != '0))
                                state_next = S_FREE_SCAN;
                            else
                                state_next = S_SEND_STORE;
                        end
                        CMD_RECV:
                        begin
                            if ((req.receiver_id == '0) || (req.capacity == '0))
                                state_next = S_EMIT;
                            else
                                state_next = S_SCAN_RD;
                        end
                        CMD_PEND:
                        begin
                            if (req.receiver_id == '0)
                                state_next = S_EMIT;
                            else
                                state_next = S_SCAN_RD;
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_FREE_SCAN:
            begin
                if (!used_reg[idx_reg] || scan_end)
                    state_next = S_SEND_STORE;
            end
            S_SEND_STORE: state_next = last_reg ? S_EMIT : S_IDLE;
            S_SCAN_RD:    state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if ((cmd_reg == CMD_RECV) && scan_hit)
                    state_next = (dlv_len == '0) ? S_EMIT : S_DLV_RD;
                else if (scan_end)
                    state_next = S_EMIT;
                else
                    state_next = S_SCAN_RD;
            end
            S_DLV_RD:  state_next = S_DLV_CAP;
            S_DLV_CAP: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                    state_next = res_last_reg ? S_IDLE : S_DLV_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        used_next        = used_reg;
        send_active_next = send_active_reg;
        send_slot_next   = send_slot_reg;
        send_count_next  = send_count_reg;
        send_failed_next = send_failed_reg;
        send_rcv_next    = send_rcv_reg;
        send_snd_next    = send_snd_reg;
        cmd_next         = cmd_reg;
        rcv_next         = rcv_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        cap_next         = cap_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        hit_slot_next    = hit_slot_reg;
        hit_snd_next     = hit_snd_reg;
        dlv_n_next       = dlv_n_reg;
        dlv_j_next       = dlv_j_reg;
        res_status_next  = res_status_reg;
        res_byte_next    = res_byte_reg;
        res_last_next    = res_last_reg;
        res_snd_next     = res_snd_reg;
        res_count_next   = res_count_reg;
        ov_next          = ov_reg;
        o_status_next    = o_status_reg;
        o_byte_next      = o_byte_reg;
        o_last_next      = o_last_reg;
        o_snd_next       = o_snd_reg;
        o_count_next     = o_count_reg;

        // output register drains on transfer
        if (rsp.ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    cmd_next        = req.command;
                    rcv_next        = req.receiver_id;
                    byte_next       = req.data_byte;
                    last_next       = req.byte_last;
                    cap_next        = req.capacity;
                    idx_next        = '0;
                    pend_next       = '0;
                    res_status_next = ST_ERR;
                    res_byte_next   = '0;
                    res_last_next   = 1'b1;
                    res_snd_next    = '0;
                    res_count_next  = '0;
                    if ((req.command == CMD_SEND) && !send_active_reg)
                    begin
                        send_active_next = 1'b1;
                        send_count_next  = '0;
                        send_failed_next = 1'b1;
                        send_slot_next   = '0;
                        send_rcv_next    = req.receiver_id;
                        send_snd_next    = req.sender_id;
                    end
                    if (req.command == CMD_PEND)
                        res_status_next = ST_OK;
                end
            end
            S_FREE_SCAN:
            begin
                if (!used_reg[idx_reg])
                begin
                    send_slot_next   = idx_reg;
                    send_failed_next = 1'b0;
                end
                idx_next = idx_reg + SLOT_W'(1);
            end
            S_SEND_STORE:
            begin
                if (store_ok)
                    send_count_next = count_inc;
                else
                    send_failed_next = 1'b1;
                if (last_reg)
                begin
                    send_active_next = 1'b0;
                    send_failed_next = 1'b0;
                    send_count_next  = '0;
                    if (!fail_now)
                    begin
                        used_next[send_slot_reg] = 1'b1;
                        res_status_next          = ST_OK;
                        res_count_next           = count_inc;
                    end
                end
            end
            S_SCAN_CMP:
            begin
                if (cmd_reg == CMD_RECV)
                begin
                    if (scan_hit)
                    begin
                        used_next[idx_reg] = 1'b0;
                        hit_slot_next      = idx_reg;
                        hit_snd_next       = meta_rd.sender;
                        dlv_n_next         = dlv_len;
                        dlv_j_next         = '0;
                        res_status_next    = ST_OK;
                        res_snd_next       = meta_rd.sender;
                    end
                    else if (scan_end)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                end
                else if (scan_end)
                begin
                    res_status_next = ST_OK;
                    res_count_next  = (scan_hit && (pend_reg != PEND_MAX))
                                      ? pend_reg + LEN_W'(1) : pend_reg;
                end
                if (scan_hit && (pend_reg != PEND_MAX))
                    pend_next = pend_reg + LEN_W'(1);
                idx_next = idx_reg + SLOT_W'(1);
            end
            S_DLV_CAP:
            begin
                res_status_next = ST_OK;
                res_byte_next   = byte_rdata;
                res_last_next   = dlv_end;
                res_snd_next    = hit_snd_reg;
                res_count_next  = dlv_n_reg;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = res_status_reg;
                    o_byte_next   = res_byte_reg;
                    o_last_next   = res_last_reg;
                    o_snd_next    = res_snd_reg;
                    o_count_next  = res_count_reg;
                    dlv_j_next    = dlv_j_reg + LEN_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= '0;
            send_active_reg <= 1'b0;
            send_slot_reg   <= '0;
            send_count_reg  <= '0;
            send_failed_reg <= 1'b0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            send_active_reg <= send_active_next;
            send_slot_reg   <= send_slot_next;
            send_count_reg  <= send_count_next;
            send_failed_reg <= send_failed_next;
            ov_reg          <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        send_rcv_reg   <= send_rcv_next;
        send_snd_reg   <= send_snd_next;
        cmd_reg        <= cmd_next;
        rcv_reg        <= rcv_next;
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        cap_reg        <= cap_next;
        idx_reg        <= idx_next;
        pend_reg       <= pend_next;
        hit_slot_reg   <= hit_slot_next;
        hit_snd_reg    <= hit_snd_next;
        dlv_n_reg      <= dlv_n_next;
        dlv_j_reg      <= dlv_j_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_last_reg   <= res_last_next;
        res_snd_reg    <= res_snd_next;
        res_count_reg  <= res_count_next;
        o_status_reg   <= o_status_next;
        o_byte_reg     <= o_byte_next;
        o_last_reg     <= o_last_next;
        o_snd_reg      <= o_snd_next;
        o_count_reg    <= o_count_next;
    end

    // response port
    assign rsp.valid         = ov_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.byte_value    = o_byte_reg;
    assign rsp.result_last   = o_last_reg;
    assign rsp.sender_id_out = o_snd_reg;
    assign rsp.count         = o_count_reg;

    // checks
    `MSM_ASSERT_SAME(a_send_count_bound, clk, rst_n, send_active_reg,
        send_count_reg <= MSG_MAX, "send count past message size")
    `MSM_ASSERT_SAME(a_empty_is_final, clk, rst_n, rsp.valid && (rsp.status == ST_EMPTY),
        rsp.result_last && (rsp.count == '0), "empty result not final or nonzero count")
    `MSM_ASSERT_NEXT(a_claim_on_success, clk, rst_n, meta_we,
        used_reg[$past(send_slot_reg)], "slot not marked used after good send")
    `MSM_ASSERT_NEXT(a_more_bytes_follow, clk, rst_n,
        (state_reg == S_EMIT) && out_free && !res_last_reg,
        state_reg == S_DLV_RD, "delivery did not continue after a non-final byte")

endmodule

[verif/msm_tb_if.sv]
// ----------------------------------------------------------------------------
// msm_tb_if
// mailbox testbench settings (package msm_tb_pkg), kept with the testbench so it builds on its own
// ----------------------------------------------------------------------------
// the rtl folder already defines msm_req_if and msm_rsp_if; the testbench
// compiles against those, so this file only carries msm_tb_pkg and a note
// for the build order: package, interfaces, rtl, checker, top
package msm_tb_pkg;
    localparam int TB_LATENCY = 400;
endpackage

[verif/msm_checker.sv]
// ----------------------------------------------------------------------------
// msm_checker
// watches both mailbox channels, predicts responses and compares them
// ----------------------------------------------------------------------------
module msm_checker import msm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    msm_req_if         req,
    msm_rsp_if         rsp,
    output int         errors,
    output int         waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int MSG_BYTES = MESSAGE_BYTES_DEF;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] byte_value;
        logic              result_last;
        logic [ID_W-1:0]   sender_id_out;
        logic [LEN_W-1:0]  count;
    } reply_t;

    // mirror of the slot table
    logic              mb_used [SLOTS];
    logic [ID_W-1:0]   mb_rcv [SLOTS];
    logic [ID_W-1:0]   mb_snd [SLOTS];
    int                mb_len [SLOTS];
    logic [BYTE_W-1:0] mb_data [SLOTS][MSG_BYTES];
    logic              run_open;
    int                run_slot;
    int                run_len;
    logic              run_bad;
    reply_t            pending_replies[$];

    assign waiting = pending_replies.size();

    function automatic reply_t mk(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b,
                                  logic l, logic [ID_W-1:0] s, int c);
        reply_t r;
        r.status = st;
        r.byte_value = b;
        r.result_last = l;
        r.sender_id_out = s;
        r.count = c[LEN_W-1:0];
        return r;
    endfunction

    // mailbox behavior for one accepted request
    task automatic predict_mailbox(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] rcv,
                                   logic [ID_W-1:0] snd, logic [BYTE_W-1:0] b,
                                   logic lst, logic [LEN_W-1:0] cap);
        int hit;
        int n;
        int c;
        hit = -1;
        c = 0;
        if (cmd == CMD_SEND)
        begin
            if (!run_open)
            begin
                run_open = 1'b1;
                run_len = 0;
                run_bad = 1'b1;
                run_slot = 0;
                if (rcv != 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!mb_used[i] && run_bad)
                        begin
                            run_slot = i;
                            run_bad = 1'b0;
                            mb_rcv[i] = rcv;
                            mb_snd[i] = snd;
                        end
                    end
                end
            end
            if (!run_bad)
            begin
                if (run_len < MSG_BYTES)
                begin
                    mb_data[run_slot][run_len] = b;
                    run_len++;
                end
                else
                    run_bad = 1'b1;
            end
            if (lst)
            begin
                run_open = 1'b0;
                if (run_bad)
                    pending_replies.push_back(mk(ST_ERR, '0, 1'b1, '0, 0));
                else
                begin
                    mb_used[run_slot] = 1'b1;
                    mb_len[run_slot] = run_len;
                    pending_replies.push_back(mk(ST_OK, '0, 1'b1, '0, run_len));
                end
                run_bad = 1'b0;
                run_len = 0;
            end
        end
        else if (cmd == CMD_RECV)
        begin
            if (rcv == 0 || cap == 0)
                pending_replies.push_back(mk(ST_ERR, '0, 1'b1, '0, 0));
            else
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (mb_used[i] && mb_rcv[i] == rcv)
                        hit = i;
                if (hit < 0)
                    pending_replies.push_back(mk(ST_EMPTY, '0, 1'b1, '0, 0));
                else
                begin
                    n = mb_len[hit];
                    if (n > int'(cap))
                        n = int'(cap);
                    mb_used[hit] = 1'b0;
                    if (n == 0)
                        pending_replies.push_back(mk(ST_OK, '0, 1'b1, mb_snd[hit], 0));
                    for (int j = 0; j < n; j++)
                        pending_replies.push_back(mk(ST_OK, mb_data[hit][j],
                                                     j + 1 == n, mb_snd[hit], n));
                end
            end
        end
        else if (cmd == CMD_PEND)
        begin
            if (rcv != 0)
                for (int i = 0; i < SLOTS; i++)
                    if (mb_used[i] && mb_rcv[i] == rcv)
                        c++;
            if (c > 127)
                c = 127;
            pending_replies.push_back(mk(ST_OK, '0, 1'b1, '0, c));
        end
        else
            pending_replies.push_back(mk(ST_ERR, '0, 1'b1, '0, 0));
    endtask

    // sample transfers on the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            errors <= 0;
            run_open = 1'b0;
            run_bad = 1'b0;
            run_len = 0;
            run_slot = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                mb_used[i] = 1'b0;
                mb_len[i] = 0;
            end
            pending_replies.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.byte_value, rsp.result_last,
                       rsp.sender_id_out, rsp.count};
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected response, actual %h", $realtime, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: response mismatch, expected %h actual %h",
                                 $realtime, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_mailbox(req.command, req.receiver_id, req.sender_id,
                                req.data_byte, req.byte_last, req.capacity);
        end
    end
endmodule

[verif/tb_message_slot_mailbox.sv]
// ----------------------------------------------------------------------------
// tb_message_slot_mailbox
// drives sends, receives, pending counts and unknown commands with random gaps and stalls;
// the checker predicts every response and counts mismatches
// ----------------------------------------------------------------------------
module tb_message_slot_mailbox import msm_pkg::*, msm_tb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // command code outside the defined set
    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

    logic clk;
    logic rst_n;
    int   errors;
    int   waiting;
    int   cycles;
    int   sent;

    msm_req_if req ();
    msm_rsp_if rsp ();

    message_slot_mailbox dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    msm_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                     .errors(errors), .waiting(waiting));

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // one request transfer, with a random idle gap first; called at a falling edge
    task automatic put_req(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] rcv,
                           logic [ID_W-1:0] snd, logic [BYTE_W-1:0] b,
                           logic lst, logic [LEN_W-1:0] cap);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.receiver_id <= rcv;
        req.sender_id <= snd;
        req.data_byte <= b;
        req.byte_last <= lst;
        req.capacity <= cap;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // whole send run of len bytes
    task automatic send_msg(logic [ID_W-1:0] rcv, logic [ID_W-1:0] snd, int len);
        for (int i = 0; i < len; i++)
            put_req(CMD_SEND, rcv, snd, BYTE_W'($urandom), i == len - 1,
                    LEN_W'($urandom));
    endtask

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("message_slot_mailbox regression: fail");
                $finish;
            end
        end
    end

    // response stalls
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cycles % 600 < 150)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
                             ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        sent = 0;
        req.valid = 1'b0;
        req.command = CMD_SEND;
        req.receiver_id = '0;
        req.sender_id = '0;
        req.data_byte = '0;
        req.byte_last = 1'b0;
        req.capacity = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: edge ids, full and overlong runs, errors, empty, unknown
        send_msg(16'hFFFF, 16'hFFFF, 64);
        send_msg(16'h0001, 16'h0000, 1);
        send_msg(16'h0000, 16'h1234, 3);
        send_msg(16'h0002, 16'hAAAA, 65);
        put_req(CMD_PEND, 16'hFFFF, '0, '0, 1'b0, '0);
        put_req(CMD_PEND, 16'h0000, '0, '0, 1'b0, '0);
        put_req(CMD_RECV, 16'h0000, '0, '0, 1'b0, 7'd5);
        put_req(CMD_RECV, 16'hFFFF, '0, '0, 1'b0, 7'd0);
        put_req(CMD_RECV, 16'hFFFF, '0, 8'hFF, 1'b1, 7'd127);
        put_req(CMD_RECV, 16'h0001, 16'hFFFF, '0, 1'b0, 7'd64);
        put_req(CMD_RECV, 16'h0001, '0, '0, 1'b0, 7'd1);
        put_req(CMD_BAD, 16'h5555, 16'h5555, 8'hFF, 1'b1, 7'd127);
        for (int i = 0; i < 17; i++)
            send_msg(16'h0007, ID_W'(i), 1);
        put_req(CMD_PEND, 16'h0007, '0, '0, 1'b0, '0);

        // hold the sender until the mailbox drains
        req.valid <= 1'b0;
        wait (waiting == 0);
        @(negedge clk);

        // random: mostly well-formed traffic among a few receivers
        while (sent < 180)
        begin
            case ($urandom_range(0, 9)) inside
                [0:3]:
                begin
                    send_msg(($urandom_range(0, 15) == 0) ? 16'h0 :
                             ID_W'($urandom_range(1, 4)),
                             ID_W'($urandom), $urandom_range(1, 6));
                end
                [4:6]:
                    put_req(CMD_RECV, ID_W'($urandom_range(0, 5)), ID_W'($urandom),
                            BYTE_W'($urandom), 1'($urandom),
                            ($urandom_range(0, 7) == 0) ?
                            LEN_W'($urandom_range(0, 127)) :
                            LEN_W'($urandom_range(1, 8)));
                [7:8]:
                    put_req(CMD_PEND, ID_W'($urandom_range(0, 5)), ID_W'($urandom),
                            BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
                default:
                    put_req(($urandom_range(0, 1) == 0) ? CMD_BAD : CMD_PEND,
                            ID_W'($urandom), ID_W'($urandom), BYTE_W'($urandom),
                            1'($urandom), LEN_W'($urandom));
            endcase
        end

        // drain, then settle
        req.valid <= 1'b0;
        wait (waiting == 0);
        repeat (TB_LATENCY) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("message_slot_mailbox regression: pass");
        else
            $display("message_slot_mailbox regression: fail");
        $finish;
    end
endmodule
